>>> rtl/world_to_screen_projection_macros.svh
// Assertion macros shared by the projection block.
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define WSP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WSP_ASSERT(label, clk, rst, prop, msg)
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/wsp_pkg.sv
package wsp_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int NUM_COEF  = 32;
  localparam int IDX_W     = 5;
  localparam int MAT_SIZE  = 16;
  localparam int VIEW_BASE = 0;
  localparam int PROJ_BASE = 16;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DIV_W     = COEF_W + FRAC_BITS;
  localparam int VP_W      = 14;
  localparam int MAP_W     = COEF_W + 1 + VP_W + 1;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 1'd1;
  localparam logic [VP_W-1:0] VP_WIDTH_RST  = 14'd1920;
  localparam logic [VP_W-1:0] VP_HEIGHT_RST = 14'd1080;

  // The value 1.0 in the fixed-point format, one bit wider than a coefficient.
  localparam logic signed [COEF_W:0] ONE = (COEF_W + 1)'(64'd1 << FRAC_BITS);

  // Queue and in-flight accounting.
  localparam int QUEUE_DEPTH  = 4;
  localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PIPE_DEPTH   = 2 + 2 + DIV_W + 3;
  localparam int INFLIGHT_MAX = QUEUE_DEPTH + PIPE_DEPTH;
  localparam int CNT_W        = $clog2(INFLIGHT_MAX + 1);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_POINT = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_VISIBLE   = 2'd0,
    ST_BEHIND    = 2'd1,
    ST_OFFSCREEN = 2'd2
  } status_t;

  typedef logic signed [COEF_W-1:0] fix_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } point_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } tag_t;

  typedef struct packed {
    logic push;
    logic load;
  } front_evt_t;

  // Saturate a wide sum to the coefficient range.
  function automatic fix_t sat_fix(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    begin
      hi = PROD_W'(fix_t'({1'b0, {(COEF_W-1){1'b1}}}));
      lo = PROD_W'(fix_t'({1'b1, {(COEF_W-1){1'b0}}}));
      if (v > hi) begin
        return fix_t'(hi);
      end else if (v < lo) begin
        return fix_t'(lo);
      end
      return fix_t'(v);
    end
  endfunction

  // Magnitude of a signed value as an unsigned word.
  function automatic logic [COEF_W-1:0] abs_mag(input fix_t v);
    begin
      return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
    end
  endfunction

endpackage

>>> rtl/wsp_channels.sv
// Request channel: coefficient loads and points.
interface wsp_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [wsp_pkg::IDX_W-1:0]  coef_index;
  wsp_pkg::fix_t              coef_value;
  wsp_pkg::fix_t              point_x;
  wsp_pkg::fix_t              point_y;
  wsp_pkg::fix_t              point_z;

  modport source (output valid, req_type, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, req_type, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

// Result channel: projected screen position and status.
interface wsp_res_if;
  logic          valid;
  logic          ready;
  wsp_pkg::fix_t screen_x;
  wsp_pkg::fix_t screen_y;
  logic [1:0]    status;

  modport source (output valid, screen_x, screen_y, status, input ready);
  modport sink (input valid, screen_x, screen_y, status, output ready);
endinterface

>>> rtl/wsp_front.sv
module wsp_front (
  input  logic                clk,
  input  logic                rst,
  wsp_req_if.sink             req,
  input  logic                queue_full,
  input  logic                back_idle,
  output wsp_pkg::point_t     push_point,
  output wsp_pkg::front_evt_t evt,
  output wsp_pkg::fix_t       coef [wsp_pkg::NUM_COEF]
);

  logic                      hold_valid;
  logic                      hold_type;
  logic [wsp_pkg::IDX_W-1:0] hold_index;
  wsp_pkg::fix_t             hold_value;
  wsp_pkg::point_t           hold_point;
  logic                      hold_go;

  // A point leaves when the queue has room; a load waits until no point is in flight.
  always_comb begin
    if (hold_type == wsp_pkg::REQ_POINT) begin
      hold_go = hold_valid && !queue_full;
    end else begin
      hold_go = hold_valid && back_idle;
    end
    req.ready  = !hold_valid || hold_go;
    evt.push   = hold_go && (hold_type == wsp_pkg::REQ_POINT);
    evt.load   = hold_go && (hold_type == wsp_pkg::REQ_LOAD);
    push_point = hold_point;
  end

  // Holding register for the item taken in the last transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold_type    <= req.req_type;
      hold_index   <= req.coef_index;
      hold_value   <= req.coef_value;
      hold_point.x <= req.point_x;
      hold_point.y <= req.point_y;
      hold_point.z <= req.point_z;
    end
  end

  // Coefficient store for both matrices.
  always_ff @(posedge clk) begin
    if (evt.load) begin
      coef[hold_index] <= hold_value;
    end
  end

endmodule

>>> rtl/wsp_queue.sv
module wsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsp_pkg::point_t din,
  input  logic            pop,
  output wsp_pkg::point_t dout,
  output logic            full,
  output logic            empty
);

  wsp_pkg::point_t              slots [wsp_pkg::QUEUE_DEPTH];
  logic [wsp_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [wsp_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [wsp_pkg::Q_CNT_W-1:0]  fill;

  assign full  = (fill == wsp_pkg::Q_CNT_W'(wsp_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + wsp_pkg::Q_CNT_W'(push) - wsp_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/wsp_matvec.sv
module wsp_matvec (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  wsp_pkg::tag_t in_tag,
  input  wsp_pkg::fix_t vec [4],
  input  wsp_pkg::fix_t mat [wsp_pkg::MAT_SIZE],
  output wsp_pkg::tag_t out_tag,
  output wsp_pkg::fix_t res [4]
);

  logic signed [wsp_pkg::PROD_W-1:0] prod [wsp_pkg::MAT_SIZE];
  wsp_pkg::tag_t                     prod_tag;
  logic signed [wsp_pkg::PROD_W-1:0] acc  [4];

  // First stage: sixteen products, one per coefficient.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < wsp_pkg::MAT_SIZE; i++) begin
        prod[i] <= wsp_pkg::PROD_W'(mat[i]) * wsp_pkg::PROD_W'(vec[i % 4]);
      end
    end
  end

  // Row sums of the floored, rescaled products.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = (prod[r*4]     >>> wsp_pkg::FRAC_BITS) + (prod[r*4 + 1] >>> wsp_pkg::FRAC_BITS)
             + (prod[r*4 + 2] >>> wsp_pkg::FRAC_BITS) + (prod[r*4 + 3] >>> wsp_pkg::FRAC_BITS);
    end
  end

  // Second stage: saturated row results.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        res[r] <= wsp_pkg::sat_fix(acc[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_tag <= '0;
      out_tag  <= '0;
    end else if (adv) begin
      prod_tag <= in_tag;
      out_tag  <= prod_tag;
    end
  end

endmodule

>>> rtl/wsp_div.sv
module wsp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  wsp_pkg::tag_t               in_tag,
  input  logic [wsp_pkg::DIV_W-1:0]   num_x,
  input  logic [wsp_pkg::DIV_W-1:0]   num_y,
  input  logic [wsp_pkg::COEF_W-1:0]  den,
  input  logic                        neg_x,
  input  logic                        neg_y,
  output wsp_pkg::tag_t               out_tag,
  output logic [wsp_pkg::DIV_W-1:0]   quo_x,
  output logic [wsp_pkg::DIV_W-1:0]   quo_y,
  output logic                        out_neg_x,
  output logic                        out_neg_y
);

  localparam int N = wsp_pkg::DIV_W;
  localparam int W = wsp_pkg::COEF_W;

  typedef struct packed {
    logic [N-1:0] nx;
    logic [N-1:0] ny;
    logic [N-1:0] qx;
    logic [N-1:0] qy;
    logic [W-1:0] rx;
    logic [W-1:0] ry;
    logic [W-1:0] den;
    logic         negx;
    logic         negy;
  } div_stage_t;

  div_stage_t    st [N+1];
  wsp_pkg::tag_t tg [N+1];

  // One restoring step: quotient bit on top, new remainder below.
  function automatic logic [W:0] div_step(input logic [W-1:0] r, input logic b,
                                          input logic [W-1:0] d);
    logic [W:0] t;
    logic       ge;
    begin
      t  = {r, b};
      ge = (t >= {1'b0, d});
      return {ge, ge ? W'(t - {1'b0, d}) : W'(t)};
    end
  endfunction

  // Stage zero is the incoming operand set.
  always_comb begin
    st[0].nx   = num_x;
    st[0].ny   = num_y;
    st[0].qx   = '0;
    st[0].qy   = '0;
    st[0].rx   = '0;
    st[0].ry   = '0;
    st[0].den  = den;
    st[0].negx = neg_x;
    st[0].negy = neg_y;
    tg[0]      = in_tag;
  end

  // One quotient bit per stage for both lanes.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0] sx;
    logic [W:0] sy;

    assign sx = div_step(st[k-1].rx, st[k-1].nx[N-1], st[k-1].den);
    assign sy = div_step(st[k-1].ry, st[k-1].ny[N-1], st[k-1].den);

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k].nx   <= st[k-1].nx << 1;
        st[k].ny   <= st[k-1].ny << 1;
        st[k].qx   <= {st[k-1].qx[N-2:0], sx[W]};
        st[k].qy   <= {st[k-1].qy[N-2:0], sy[W]};
        st[k].rx   <= sx[W-1:0];
        st[k].ry   <= sy[W-1:0];
        st[k].den  <= st[k-1].den;
        st[k].negx <= st[k-1].negx;
        st[k].negy <= st[k-1].negy;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k] <= '0;
      end else if (adv) begin
        tg[k] <= tg[k-1];
      end
    end
  end

  assign out_tag   = tg[N];
  assign quo_x     = st[N].qx;
  assign quo_y     = st[N].qy;
  assign out_neg_x = st[N].negx;
  assign out_neg_y = st[N].negy;

endmodule

>>> rtl/world_to_screen_projection.sv
// Channel   Direction  Carries
// req       in         coefficient load or world point
// res       out        screen_x, screen_y, status (one per point)
// cfg       in         viewport width and height writes
//
// Points stream at one per cycle while res is not stalled; after its transfer a point passes
// through the queue slot, the two two-stage matrix units, the 48-stage one-bit-per-stage
// divider and the three registers after it. A load is held in the front until every point
// in flight has been delivered. Reset clears the control state; the
// coefficient store is undefined until loaded.
// A stall on res freezes the back pipeline; the four-entry queue keeps req moving meanwhile.
`include "world_to_screen_projection_macros.svh"

module world_to_screen_projection (
  input  logic                          clk,
  input  logic                          rst,
  wsp_req_if.sink                       req,
  wsp_res_if.source                     res,
  input  logic                          cfg_write,
  input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsp_pkg::VP_W-1:0]      cfg_data
);

  localparam int W = wsp_pkg::COEF_W;
  localparam int N = wsp_pkg::DIV_W;
  localparam int M = wsp_pkg::MAP_W;

  logic [wsp_pkg::VP_W-1:0]  vp_width;
  logic [wsp_pkg::VP_W-1:0]  vp_height;
  logic [wsp_pkg::CNT_W-1:0] cnt;
  logic                      adv;

  wsp_pkg::point_t     push_point;
  wsp_pkg::front_evt_t evt;
  wsp_pkg::fix_t       coef [wsp_pkg::NUM_COEF];

  wsp_pkg::point_t q_dout;
  logic            q_full;
  logic            q_empty;
  logic            pop;

  wsp_pkg::tag_t view_in_tag;
  wsp_pkg::fix_t view_vec [4];
  wsp_pkg::fix_t view_mat [wsp_pkg::MAT_SIZE];
  wsp_pkg::tag_t vw_tag;
  wsp_pkg::fix_t vw [4];

  wsp_pkg::tag_t proj_in_tag;
  wsp_pkg::fix_t proj_mat [wsp_pkg::MAT_SIZE];
  wsp_pkg::tag_t cl_tag;
  wsp_pkg::fix_t cl [4];

  wsp_pkg::tag_t  div_in_tag;
  wsp_pkg::tag_t  dq_tag;
  logic [N-1:0]   quo_x;
  logic [N-1:0]   quo_y;
  logic           dq_neg_x;
  logic           dq_neg_y;

  logic           fits_x;
  logic           fits_y;
  wsp_pkg::tag_t  nd_tag;
  wsp_pkg::fix_t  ndx;
  wsp_pkg::fix_t  ndy;

  wsp_pkg::tag_t     mp_tag;
  logic signed [M-1:0] px;
  logic signed [M-1:0] py;
  logic signed [M-1:0] sx;
  logic signed [M-1:0] sy;
  logic signed [M-1:0] wq;
  logic signed [M-1:0] hq;
  wsp_pkg::status_t    fin_status;

  // The back pipeline moves whenever the output register can take a result.
  assign adv = !res.valid || res.ready;
  assign pop = adv && !q_empty;

  // Viewport registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= wsp_pkg::VP_WIDTH_RST;
      vp_height <= wsp_pkg::VP_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wsp_pkg::CFG_VP_WIDTH:  vp_width  <= cfg_data;
        wsp_pkg::CFG_VP_HEIGHT: vp_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Points between queue entry and result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + wsp_pkg::CNT_W'(evt.push) - wsp_pkg::CNT_W'(res.valid && res.ready);
    end
  end

  wsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .queue_full (q_full),
    .back_idle  (cnt == '0),
    .push_point (push_point),
    .evt        (evt),
    .coef       (coef)
  );

  wsp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (evt.push),
    .din   (push_point),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // View transform operands: the point with w of one.
  always_comb begin
    view_in_tag.valid  = pop;
    view_in_tag.status = wsp_pkg::ST_VISIBLE;
    view_vec[0] = q_dout.x;
    view_vec[1] = q_dout.y;
    view_vec[2] = q_dout.z;
    view_vec[3] = wsp_pkg::fix_t'(wsp_pkg::ONE);
    for (int i = 0; i < wsp_pkg::MAT_SIZE; i++) begin
      view_mat[i] = coef[wsp_pkg::VIEW_BASE + i];
      proj_mat[i] = coef[wsp_pkg::PROJ_BASE + i];
    end
  end

  wsp_matvec u_view (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (view_in_tag),
    .vec     (view_vec),
    .mat     (view_mat),
    .out_tag (vw_tag),
    .res     (vw)
  );

  // A point behind the camera plane (positive view z) is rejected here.
  always_comb begin
    proj_in_tag.valid  = vw_tag.valid;
    proj_in_tag.status = (vw[2] > 0) ? wsp_pkg::ST_BEHIND : wsp_pkg::ST_VISIBLE;
  end

  wsp_matvec u_proj (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (proj_in_tag),
    .vec     (vw),
    .mat     (proj_mat),
    .out_tag (cl_tag),
    .res     (cl)
  );

  // A zero w cannot be divided by.
  always_comb begin
    div_in_tag.valid = cl_tag.valid;
    if (cl_tag.status == wsp_pkg::ST_VISIBLE && cl[3] == '0) begin
      div_in_tag.status = wsp_pkg::ST_OFFSCREEN;
    end else begin
      div_in_tag.status = cl_tag.status;
    end
  end

  wsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_tag    (div_in_tag),
    .num_x     ({wsp_pkg::abs_mag(cl[0]), {wsp_pkg::FRAC_BITS{1'b0}}}),
    .num_y     ({wsp_pkg::abs_mag(cl[1]), {wsp_pkg::FRAC_BITS{1'b0}}}),
    .den       (wsp_pkg::abs_mag(cl[3])),
    .neg_x     (cl[0][W-1] ^ cl[3][W-1]),
    .neg_y     (cl[1][W-1] ^ cl[3][W-1]),
    .out_tag   (dq_tag),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .out_neg_x (dq_neg_x),
    .out_neg_y (dq_neg_y)
  );

  // Quotient range check: a negative result may reach one more step.
  always_comb begin
    fits_x = dq_neg_x ? (quo_x <= N'(64'd1 << (W - 1))) : (quo_x < N'(64'd1 << (W - 1)));
    fits_y = dq_neg_y ? (quo_y <= N'(64'd1 << (W - 1))) : (quo_y < N'(64'd1 << (W - 1)));
  end

  // Signed normalised coordinates.
  always_ff @(posedge clk) begin
    if (adv) begin
      ndx <= dq_neg_x ? wsp_pkg::fix_t'(-quo_x[W-1:0]) : wsp_pkg::fix_t'(quo_x[W-1:0]);
      ndy <= dq_neg_y ? wsp_pkg::fix_t'(-quo_y[W-1:0]) : wsp_pkg::fix_t'(quo_y[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nd_tag <= '0;
    end else if (adv) begin
      nd_tag.valid <= dq_tag.valid;
      if (dq_tag.status == wsp_pkg::ST_VISIBLE && !(fits_x && fits_y)) begin
        nd_tag.status <= wsp_pkg::ST_OFFSCREEN;
      end else begin
        nd_tag.status <= dq_tag.status;
      end
    end
  end

  // Viewport scaling products.
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= M'((W + 1)'(ndx) + wsp_pkg::ONE) * M'($signed({1'b0, vp_width}));
      py <= M'(wsp_pkg::ONE - (W + 1)'(ndy)) * M'($signed({1'b0, vp_height}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_tag <= '0;
    end else if (adv) begin
      mp_tag <= nd_tag;
    end
  end

  // Halve with floor and test against the viewport bounds.
  always_comb begin
    sx = px >>> 1;
    sy = py >>> 1;
    wq = M'({vp_width, {wsp_pkg::FRAC_BITS{1'b0}}});
    hq = M'({vp_height, {wsp_pkg::FRAC_BITS{1'b0}}});
    if (mp_tag.status == wsp_pkg::ST_VISIBLE &&
        (sx > wq || sx < -wq || sy > hq || sy < -hq)) begin
      fin_status = wsp_pkg::ST_OFFSCREEN;
    end else begin
      fin_status = mp_tag.status;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= mp_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.status   <= fin_status;
      res.screen_x <= (fin_status == wsp_pkg::ST_VISIBLE) ? wsp_pkg::fix_t'(sx[W-1:0]) : '0;
      res.screen_y <= (fin_status == wsp_pkg::ST_VISIBLE) ? wsp_pkg::fix_t'(sy[W-1:0]) : '0;
    end
  end

  // Checks on ordering of loads, queue use and result fields.
  `WSP_ASSERT(a_load_when_idle, clk, rst, evt.load |-> (cnt == '0), "coefficient written while points in flight")
  `WSP_ASSERT(a_queue_no_overflow, clk, rst, evt.push |-> !q_full, "push into a full queue")
  `WSP_ASSERT(a_cnt_bound, clk, rst, cnt <= wsp_pkg::CNT_W'(wsp_pkg::INFLIGHT_MAX), "in-flight count out of range")
  `WSP_ASSERT(a_hidden_zero, clk, rst, (res.valid && res.status != wsp_pkg::ST_VISIBLE) |-> (res.screen_x == '0 && res.screen_y == '0), "rejected point carries a position")
  `WSP_ASSERT_NEXT(a_cnt_push, clk, rst, evt.push && !(res.valid && res.ready), cnt == $past(cnt) + wsp_pkg::CNT_W'(1), "in-flight count missed a push")

endmodule
